FILE: hw/rtl/sds_pkg.sv
// ----------------------------------------------------------------------------
// sds_pkg
// Shared types and constants of the SCAN disk scheduler.
// ----------------------------------------------------------------------------
package sds_pkg;

  localparam int MaxRequests = 32;
  localparam int TrackBits   = 16;
  localparam int SeekBits    = TrackBits + 1;
  localparam int CntBits     = $clog2(MaxRequests + 1);
  localparam int IdxBits     = $clog2(MaxRequests);
  localparam int OutDataBits = ((TrackBits + SeekBits + 7) / 8) * 8;
  localparam int OutUserBits = 2;
  localparam int CfgIdxBits  = 2;

  localparam logic [TrackBits-1:0] DiskEndRst   = TrackBits'(199);
  localparam logic [TrackBits-1:0] HeadStartRst = '0;
  localparam logic                 SweepRst     = 1'b1;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_DISK_END    = 2'd0,
    CFG_HEAD_START  = 2'd1,
    CFG_SWEEP_RIGHT = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SPLIT,
    ST_FIRST,
    ST_TURN,
    ST_SECOND
  } ctrl_state_e;

  typedef struct packed {
    logic [TrackBits-1:0] disk_end;
    logic [TrackBits-1:0] head_start;
    logic                 sweep_right;
  } cfg_t;

  typedef struct packed {
    logic insert;       // store the incoming request
    logic start;        // load arm and seek for a new schedule
    logic split_step;   // advance the split scan
    logic split_latch;  // hold the split point
    logic asc;          // walk the store upward
    logic turn;         // visit the disk end
    logic second;       // second sweep is under way
    logic emit;         // load the output register with a visit
    logic clear_batch;  // drop count and overflow after the last visit
  } dp_cmd_t;

  typedef struct packed {
    logic               split_stop;
    logic               more;
    logic               turn_last;
    logic               second_last;
    logic               out_free;
    logic [CntBits-1:0] count;
  } dp_status_t;

endpackage

FILE: hw/rtl/scan_disk_scheduler_unit.sv
// ----------------------------------------------------------------------------
// scan_disk_scheduler_unit
// SCAN (elevator) disk scheduler: collects a batch of requests, then emits
// the service order with the running seek distance.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata track, tlast final_request
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata service_track, seek_total;
//                                              tuser is_turn, dropped;
//                                              tlast end_of_run
// cfg       in   cfg_valid_i/cfg_ready_o       cfg_index_i, cfg_data_i
//
// A non-final request is inserted in the sorted store.
// A final request adds a split scan that steps over one stored request per
// cycle, then one result per cycle while m_axis is free, up to 33 results;
// the first sweep ends in a state that emits no result before the turn point.
// Reset clears the batch, the arm and seek registers and loads register
// defaults; store contents are not cleared. Backpressure on m_axis holds the
// output register and the walk; s_axis is closed from the final request
// until the last result has been loaded.
// ----------------------------------------------------------------------------
module scan_disk_scheduler_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [sds_pkg::TrackBits-1:0]    s_axis_tdata,   // [15:0] track
  input  logic                             s_axis_tlast,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [sds_pkg::OutDataBits-1:0]  m_axis_tdata,   // [15:0] service_track,
                                                           // [32:16] seek_total
  output logic [sds_pkg::OutUserBits-1:0]  m_axis_tuser,   // [0] is_turn, [1] dropped
  output logic                             m_axis_tlast,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [sds_pkg::CfgIdxBits-1:0]   cfg_index_i,
  input  logic [sds_pkg::TrackBits-1:0]    cfg_data_i
);
  import sds_pkg::*;

  cfg_t       cfg_q;
  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.disk_end    <= DiskEndRst;
      cfg_q.head_start  <= HeadStartRst;
      cfg_q.sweep_right <= SweepRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_DISK_END:    cfg_q.disk_end    <= cfg_data_i;
        CFG_HEAD_START:  cfg_q.head_start  <= cfg_data_i;
        CFG_SWEEP_RIGHT: cfg_q.sweep_right <= cfg_data_i[0];
        default:         cfg_q <= cfg_q;
      endcase
    end
  end

  sds_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_valid_i     (s_axis_tvalid),
    .s_last_i      (s_axis_tlast),
    .s_ready_o     (s_axis_tready),
    .sweep_right_i (cfg_q.sweep_right),
    .status_i      (dp_status),
    .cmd_o         (dp_cmd)
  );

  sds_datapath u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .cmd_i     (dp_cmd),
    .status_o  (dp_status),
    .track_i   (s_axis_tdata),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata),
    .m_user_o  (m_axis_tuser),
    .m_last_o  (m_axis_tlast)
  );

  a_final_closes_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
    else $error("input still open after final request");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_status.count <= CntBits'(MaxRequests))
    else $error("request count beyond store capacity");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(dp_cmd.emit && m_axis_tvalid && !m_axis_tready))
    else $error("result loaded over a stalled result");

endmodule

FILE: hw/rtl/sds_datapath.sv
// ----------------------------------------------------------------------------
// sds_datapath
// Sorted request store, arm and seek registers, output register.
// ----------------------------------------------------------------------------
module sds_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  sds_pkg::cfg_t                   cfg_i,
  input  sds_pkg::dp_cmd_t                cmd_i,
  output sds_pkg::dp_status_t             status_o,
  input  logic [sds_pkg::TrackBits-1:0]   track_i,
  output logic                            m_valid_o,
  input  logic                            m_ready_i,
  output logic [sds_pkg::OutDataBits-1:0] m_data_o,
  output logic [sds_pkg::OutUserBits-1:0] m_user_o,
  output logic                            m_last_o
);
  import sds_pkg::*;

  logic [TrackBits-1:0] store_q [MaxRequests];
  logic [CntBits-1:0]   count_q, count_d;
  logic                 overflow_q, overflow_d;
  logic [TrackBits-1:0] arm_q, arm_d;
  logic [SeekBits-1:0]  seek_q, seek_d;
  logic [CntBits-1:0]   idx_q, idx_d;
  logic [CntBits-1:0]   split_q, split_d;
  logic                 out_valid_q, out_valid_d;
  logic [TrackBits-1:0] out_track_q;
  logic [SeekBits-1:0]  out_seek_q;
  logic                 out_turn_q, out_drop_q, out_last_q;

  logic [TrackBits-1:0] trk_c, head_c, rd_track, visit, move_len;
  logic [CntBits-1:0]   idx_m1, idx_p1;
  logic [IdxBits-1:0]   rd_sel;
  logic [MaxRequests-1:0] gt, we;
  logic [TrackBits-1:0] ins_val [MaxRequests];
  logic                 full, out_free, last_c;
  logic [SeekBits-1:0]  seek_sum;

  assign trk_c  = (track_i > cfg_i.disk_end) ? cfg_i.disk_end : track_i;
  assign head_c = (cfg_i.head_start > cfg_i.disk_end) ? cfg_i.disk_end : cfg_i.head_start;
  assign full   = (count_q == CntBits'(MaxRequests));

  always_comb begin
    for (int i = 0; i < MaxRequests; i++) begin
      gt[i] = (CntBits'(i) < count_q) && (store_q[i] > trk_c);
      we[i] = gt[i] || (CntBits'(i) == count_q);
    end
    ins_val[0] = trk_c;
    for (int i = 1; i < MaxRequests; i++) begin
      ins_val[i] = gt[i-1] ? store_q[i-1] : trk_c;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.insert && !full) begin
      for (int i = 0; i < MaxRequests; i++) begin
        if (we[i]) begin
          store_q[i] <= ins_val[i];
        end
      end
    end
  end

  assign idx_m1   = idx_q - CntBits'(1);
  assign idx_p1   = idx_q + CntBits'(1);
  assign rd_sel   = cmd_i.asc ? idx_q[IdxBits-1:0] : idx_m1[IdxBits-1:0];
  assign rd_track = store_q[rd_sel];

  assign visit    = cmd_i.turn ? (cfg_i.sweep_right ? cfg_i.disk_end : '0) : rd_track;
  assign move_len = (arm_q > visit) ? (arm_q - visit) : (visit - arm_q);
  assign seek_sum = seek_q + SeekBits'(move_len);
  assign out_free = !out_valid_q || m_ready_i;
  assign last_c   = cmd_i.turn ? status_o.turn_last
                  : (cmd_i.second ? status_o.second_last : 1'b0);

  always_comb begin
    status_o.split_stop  = (idx_q == count_q) ||
                           (cfg_i.sweep_right ? !(rd_track < arm_q) : !(rd_track <= arm_q));
    status_o.more        = cmd_i.asc ? (idx_q != count_q) : (idx_q != '0);
    status_o.turn_last   = cfg_i.sweep_right ? (split_q == '0) : (split_q == count_q);
    status_o.second_last = cmd_i.asc ? (idx_p1 == count_q) : (idx_q == CntBits'(1));
    status_o.out_free    = out_free;
    status_o.count       = count_q;
  end

  always_comb begin
    count_d     = count_q;
    overflow_d  = overflow_q;
    arm_d       = arm_q;
    seek_d      = seek_q;
    idx_d       = idx_q;
    split_d     = split_q;
    out_valid_d = out_valid_q && !m_ready_i;
    if (cmd_i.insert) begin
      if (full) begin
        overflow_d = 1'b1;
      end else begin
        count_d = count_q + CntBits'(1);
      end
    end
    if (cmd_i.start) begin
      arm_d  = head_c;
      seek_d = '0;
      idx_d  = '0;
    end
    if (cmd_i.split_step) begin
      idx_d = idx_p1;
    end
    if (cmd_i.split_latch) begin
      split_d = idx_q;
    end
    if (cmd_i.emit) begin
      arm_d       = visit;
      seek_d      = seek_sum;
      out_valid_d = 1'b1;
      if (cmd_i.turn) begin
        idx_d = split_q;
      end else begin
        idx_d = cmd_i.asc ? idx_p1 : idx_m1;
      end
    end
    if (cmd_i.clear_batch) begin
      count_d    = '0;
      overflow_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      overflow_q  <= 1'b0;
      arm_q       <= '0;
      seek_q      <= '0;
      idx_q       <= '0;
      split_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      overflow_q  <= overflow_d;
      arm_q       <= arm_d;
      seek_q      <= seek_d;
      idx_q       <= idx_d;
      split_q     <= split_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_track_q <= visit;
      out_seek_q  <= seek_sum;
      out_turn_q  <= cmd_i.turn;
      out_drop_q  <= overflow_q;
      out_last_q  <= last_c;
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_data_o  = {{(OutDataBits - TrackBits - SeekBits){1'b0}}, out_seek_q, out_track_q};
  assign m_user_o  = {out_drop_q, out_turn_q};
  assign m_last_o  = out_last_q;

endmodule

FILE: hw/rtl/sds_ctrl.sv
// ----------------------------------------------------------------------------
// sds_ctrl
// Sequencer: load requests, find the split point, emit both sweeps.
// ----------------------------------------------------------------------------
module sds_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  input  logic                s_last_i,
  output logic                s_ready_o,
  input  logic                sweep_right_i,
  input  sds_pkg::dp_status_t status_i,
  output sds_pkg::dp_cmd_t    cmd_o
);
  import sds_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        asc, turn, second;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // Decode walk direction and visit kind from the state and the sweep direction.
  always_comb begin
    asc    = 1'b1;
    turn   = 1'b0;
    second = 1'b0;
    unique case (state_q)
      ST_FIRST:  asc = sweep_right_i;
      ST_TURN:   turn = 1'b1;
      ST_SECOND: begin
        asc    = !sweep_right_i;
        second = 1'b1;
      end
      default:   asc = 1'b1;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    s_ready_o   = 1'b0;
    cmd_o       = '0;
    cmd_o.asc   = asc;
    cmd_o.turn  = turn;
    cmd_o.second = second;
    unique case (state_q)
      ST_LOAD: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.insert = 1'b1;
          if (s_last_i) begin
            cmd_o.start = 1'b1;
            state_d     = ST_SPLIT;
          end
        end
      end
      ST_SPLIT: begin
        if (status_i.split_stop) begin
          cmd_o.split_latch = 1'b1;
          state_d           = ST_FIRST;
        end else begin
          cmd_o.split_step = 1'b1;
        end
      end
      ST_FIRST: begin
        if (!status_i.more) begin
          state_d = ST_TURN;
        end else if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
        end
      end
      ST_TURN: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.turn_last) begin
            cmd_o.clear_batch = 1'b1;
            state_d           = ST_LOAD;
          end else begin
            state_d = ST_SECOND;
          end
        end
      end
      ST_SECOND: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.second_last) begin
            cmd_o.clear_batch = 1'b1;
            state_d           = ST_LOAD;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

endmodule

FILE: bench/scan_disk_scheduler_unit_test.sv
// ----------------------------------------------------------------------------
// scan_disk_scheduler_unit_test
// Self-checking bench for the SCAN disk scheduler. Batches of track requests
// go in on s_axis under a range of disk, head and direction settings. A
// scoreboard keeps its own sorted request list, builds the elevator service
// order with running seek totals, and checks every m_axis item against it,
// under random source gaps and sink backpressure and in a full-rate phase.
// ----------------------------------------------------------------------------
module scan_disk_scheduler_unit_test;
  import sds_pkg::*;

  typedef struct packed {
    logic [TrackBits-1:0] track;
    logic                 turn;
    logic [SeekBits-1:0]  seek;
    logic                 dropped;
    logic                 last;
  } visit_t;

  class scan_schedule_board;
    logic [TrackBits-1:0] disk_end;
    logic [TrackBits-1:0] head_start;
    logic                 sweep_right;
    logic [TrackBits-1:0] sorted_tracks[$];
    logic                 overflow;
    logic [TrackBits-1:0] arm;
    logic [SeekBits-1:0]  seek;
    visit_t               batch_visits[$];
    visit_t               due_visits[$];
    int                   errors;
    int                   requests;
    int                   batches;
    int                   drop_batches;
    int                   visits_checked;

    function new();
      disk_end       = DiskEndRst;
      head_start     = HeadStartRst;
      sweep_right    = SweepRst;
      overflow       = 1'b0;
      errors         = 0;
      requests       = 0;
      batches        = 0;
      drop_batches   = 0;
      visits_checked = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [TrackBits-1:0] val);
      case (idx)
        CFG_DISK_END:    disk_end = val;
        CFG_HEAD_START:  head_start = val;
        CFG_SWEEP_RIGHT: sweep_right = val[0];
        default: ;
      endcase
    endfunction

    function void add_visit(logic [TrackBits-1:0] trk, logic turn);
      logic [TrackBits-1:0] move_len;
      visit_t v;
      move_len = (arm > trk) ? arm - trk : trk - arm;
      seek = seek + SeekBits'(move_len);
      arm = trk;
      v.track   = trk;
      v.turn    = turn;
      v.seek    = seek;
      v.dropped = overflow;
      v.last    = 1'b0;
      batch_visits.push_back(v);
    endfunction

    function void note_request(logic [TrackBits-1:0] trk, logic fin);
      logic [TrackBits-1:0] t;
      int j;
      int split;
      int n;
      t = (trk > disk_end) ? disk_end : trk;
      requests++;
      if (sorted_tracks.size() < MaxRequests) begin
        j = sorted_tracks.size();
        while (j > 0 && sorted_tracks[j-1] > t) j--;
        sorted_tracks.insert(j, t);
      end else begin
        overflow = 1'b1;
      end
      if (!fin) return;
      n = sorted_tracks.size();
      arm = (head_start > disk_end) ? disk_end : head_start;
      seek = '0;
      split = 0;
      batch_visits.delete();
      if (sweep_right) begin
        while (split < n && sorted_tracks[split] < arm) split++;
        for (int i = split; i < n; i++) add_visit(sorted_tracks[i], 1'b0);
        add_visit(disk_end, 1'b1);
        for (int i = split; i > 0; i--) add_visit(sorted_tracks[i-1], 1'b0);
      end else begin
        while (split < n && sorted_tracks[split] <= arm) split++;
        for (int i = split; i > 0; i--) add_visit(sorted_tracks[i-1], 1'b0);
        add_visit('0, 1'b1);
        for (int i = split; i < n; i++) add_visit(sorted_tracks[i], 1'b0);
      end
      batch_visits[batch_visits.size()-1].last = 1'b1;
      foreach (batch_visits[k]) due_visits.push_back(batch_visits[k]);
      batches++;
      if (overflow) drop_batches++;
      sorted_tracks.delete();
      overflow = 1'b0;
    endfunction

    function void check_visit(visit_t got);
      visit_t want;
      if (due_visits.size() == 0) begin
        errors++;
        $display("%0t: unexpected visit trk=%0d turn=%0b seek=%0d drop=%0b last=%0b",
                 $time, got.track, got.turn, got.seek, got.dropped, got.last);
        return;
      end
      want = due_visits.pop_front();
      visits_checked++;
      if (got.track !== want.track || got.turn !== want.turn || got.seek !== want.seek ||
          got.dropped !== want.dropped || got.last !== want.last) begin
        errors++;
        $display("%0t: visit mismatch exp trk=%0d turn=%0b seek=%0d drop=%0b last=%0b",
                 $time, want.track, want.turn, want.seek, want.dropped, want.last);
        $display("%0t:                got trk=%0d turn=%0b seek=%0d drop=%0b last=%0b",
                 $time, got.track, got.turn, got.seek, got.dropped, got.last);
      end
    endfunction

    function int pending();
      return due_visits.size();
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [TrackBits-1:0]   s_axis_tdata = '0;
  logic                   s_axis_tlast = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OutDataBits-1:0] m_axis_tdata;
  logic [OutUserBits-1:0] m_axis_tuser;
  logic                   m_axis_tlast;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CfgIdxBits-1:0]  cfg_index_i = '0;
  logic [TrackBits-1:0]   cfg_data_i = '0;

  scan_schedule_board   sb;
  int                   items_sent = 0;
  int                   send_idle_pct = 15;
  int                   recv_idle_pct = 66;
  logic [TrackBits-1:0] batch[$];

  scan_disk_scheduler_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
        sb.check_visit({m_axis_tdata[TrackBits-1:0], m_axis_tuser[0],
                        m_axis_tdata[TrackBits+SeekBits-1:TrackBits],
                        m_axis_tuser[1], m_axis_tlast});
      end
    end
  end

  task automatic write_reg(input cfg_idx_e idx, input logic [TrackBits-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_reg(idx, val);
  endtask

  task automatic apply_config(input logic [TrackBits-1:0] de, input logic [TrackBits-1:0] hs,
                              input logic sr);
    write_reg(CFG_DISK_END, de);
    write_reg(CFG_HEAD_START, hs);
    write_reg(CFG_SWEEP_RIGHT, TrackBits'(sr));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_request(input logic [TrackBits-1:0] trk, input logic fin);
    send_idle_pct = (items_sent < 140) ? 15 : (items_sent < 280) ? 66 : 0;
    recv_idle_pct = (items_sent < 140) ? 66 : (items_sent < 280) ? 15 : 0;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= trk;
    s_axis_tlast  <= fin;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_request(trk, fin);
    items_sent++;
  endtask

  // send the batch, then drain every visit before the next settings change
  task automatic run_batch();
    foreach (batch[i]) send_request(batch[i], i == batch.size() - 1);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    int unsigned          size;
    int unsigned          pick;
    logic [TrackBits-1:0] de;
    logic [TrackBits-1:0] hs;
    logic [TrackBits-1:0] hc;
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    batch = '{16'd0};
    run_batch();
    apply_config(16'd65535, 16'd65535, 1'b0);
    batch = '{16'd65535, 16'd0, 16'd32768};
    run_batch();
    apply_config(16'd100, 16'd150, 1'b1);
    batch = '{16'd65535, 16'd100, 16'd7, 16'd100};
    run_batch();
    apply_config(16'd100, 16'd50, 1'b0);
    batch = '{16'd50, 16'd49, 16'd51, 16'd0, 16'd100};
    run_batch();
    apply_config(16'd0, 16'd0, 1'b1);
    batch = '{16'd5, 16'd0};
    run_batch();
    apply_config(16'd199, 16'd0, 1'b0);
    batch = '{16'd3};
    run_batch();

    while (items_sent < 410) begin
      if ($urandom_range(0, 2) == 0) begin
        pick = $urandom_range(0, 5);
        de = (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF :
             (pick == 2) ? TrackBits'($urandom) : TrackBits'($urandom_range(1, 400));
        pick = $urandom_range(0, 5);
        hs = (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF : (pick == 2) ? de :
             (pick == 3) ? TrackBits'($urandom) : TrackBits'($urandom_range(0, de));
        apply_config(de, hs, 1'($urandom_range(0, 1)));
      end
      de = sb.disk_end;
      hc = (sb.head_start > de) ? de : sb.head_start;
      size = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 10);
      batch.delete();
      repeat (size) begin
        pick = $urandom_range(0, 7);
        batch.push_back((pick == 0) ? TrackBits'($urandom) : (pick == 1) ? hc :
                        TrackBits'($urandom_range(0, de)));
      end
      run_batch();
    end

    repeat (40) @(posedge clk_i);
    $display("Covered %0d requests in %0d batches (%0d with dropped requests)",
             sb.requests, sb.batches, sb.drop_batches);
    $display("Checked %0d visits under idle, backpressure and full-rate phases",
             sb.visits_checked);
    if (sb.errors == 0) begin
      $display("scan_disk_scheduler_unit_test: PASS");
    end else begin
      $display("scan_disk_scheduler_unit_test: FAIL");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("scan_disk_scheduler_unit_test: FAIL");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/sds_pkg.sv
hw/rtl/sds_datapath.sv
hw/rtl/sds_ctrl.sv
hw/rtl/scan_disk_scheduler_unit.sv
bench/scan_disk_scheduler_unit_test.sv
